// File: rtl/core/esd_pkg.sv
// Shared types, character codes and helpers for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // Decoder modes, one-hot
    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_OCT   = 4'b0100,
        MODE_HEX   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eos;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] value;
        logic [1:0] digits;
    } dec_state_t;

    localparam int QUEUE_DEPTH   = 8;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_RESERVE = 4;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
    localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
    localparam logic [4:0] NO_DIGIT       = 5'd16;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // Hex digit value, NO_DIGIT when the byte is not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                diff = b - CH_ZERO;
                hex_digit = diff[4:0];
            end
            else if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            begin
                diff = b - CH_LOWER_A + 8'd10;
                hex_digit = diff[4:0];
            end
            else if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            begin
                diff = b - CH_UPPER_A + 8'd10;
                hex_digit = diff[4:0];
            end
            else
            begin
                hex_digit = NO_DIGIT;
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/esd_decode.sv
// Combinational decode step: one input byte and the current state give up to two results.
`timescale 1ns / 1ps
`default_nettype none

module esd_decode (
    input  wire esd_pkg::dec_state_t   cur,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  is_last,
    output esd_pkg::dec_state_t        nxt,
    output esd_pkg::result_pair_t      res
);

    logic [4:0] digit;
    logic [4:0] base;
    logic [1:0] digit_limit;
    logic [1:0] digits_inc;
    logic [7:0] value_acc;
    logic [7:0] oct_first;

    assign digit       = esd_pkg::hex_digit(in_byte);
    assign base        = (cur.mode == esd_pkg::MODE_OCT) ? 5'd8 : 5'd16;
    assign digit_limit = (cur.mode == esd_pkg::MODE_OCT) ? esd_pkg::OCT_MAX_DIGITS
                                                         : esd_pkg::HEX_MAX_DIGITS;
    assign digits_inc  = cur.digits + 2'd1;
    assign value_acc   = (cur.mode == esd_pkg::MODE_OCT) ? {cur.value[4:0], digit[2:0]}
                                                         : {cur.value[3:0], digit[3:0]};
    assign oct_first   = in_byte - esd_pkg::CH_ZERO;

    always_comb
    begin
        nxt = cur;
        res = '0;

        case (cur.mode)
            esd_pkg::MODE_PLAIN:
            begin
                if (in_byte == esd_pkg::CH_BACKSLASH)
                    nxt.mode = esd_pkg::MODE_ESC;
                else
                begin
                    res.first = '{data: in_byte, has_byte: 1'b1, eos: 1'b0};
                    res.count = 2'd1;
                end
            end
            esd_pkg::MODE_ESC:
            begin
                nxt.mode  = esd_pkg::MODE_PLAIN;
                res.count = 2'd1;
                res.first.has_byte = 1'b1;
                case (in_byte)
                    esd_pkg::CH_LOWER_A: res.first.data = esd_pkg::CODE_BEL;
                    esd_pkg::CH_LOWER_B: res.first.data = esd_pkg::CODE_BS;
                    esd_pkg::CH_LOWER_E: res.first.data = esd_pkg::CODE_ESC;
                    esd_pkg::CH_LOWER_F: res.first.data = esd_pkg::CODE_FF;
                    esd_pkg::CH_LOWER_N: res.first.data = esd_pkg::CODE_LF;
                    esd_pkg::CH_LOWER_R: res.first.data = esd_pkg::CODE_CR;
                    esd_pkg::CH_LOWER_T: res.first.data = esd_pkg::CODE_TAB;
                    esd_pkg::CH_LOWER_V: res.first.data = esd_pkg::CODE_VT;
                    esd_pkg::CH_LOWER_X:
                    begin
                        nxt.mode   = esd_pkg::MODE_HEX;
                        nxt.value  = 8'd0;
                        nxt.digits = 2'd0;
                        res        = '0;
                    end
                    default:
                    begin
                        if (in_byte >= esd_pkg::CH_ZERO && in_byte <= esd_pkg::CH_SEVEN)
                        begin
                            nxt.mode   = esd_pkg::MODE_OCT;
                            nxt.value  = oct_first;
                            nxt.digits = 2'd1;
                            res        = '0;
                        end
                        else
                            res.first.data = in_byte;
                    end
                endcase
            end
            esd_pkg::MODE_OCT, esd_pkg::MODE_HEX:
            begin
                if (digit < base && cur.digits < digit_limit)
                begin
                    nxt.value  = value_acc;
                    nxt.digits = digits_inc;
                    if (digits_inc >= digit_limit)
                    begin
                        res.first = '{data: value_acc, has_byte: 1'b1, eos: 1'b0};
                        res.count = 2'd1;
                        nxt       = '{mode: esd_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
                    end
                end
                else
                begin
                    // number ends here; the byte is then taken as plain text
                    res.first = '{data: cur.value, has_byte: 1'b1, eos: 1'b0};
                    res.count = 2'd1;
                    nxt       = '{mode: esd_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
                    if (in_byte == esd_pkg::CH_BACKSLASH)
                        nxt.mode = esd_pkg::MODE_ESC;
                    else
                    begin
                        res.second = '{data: in_byte, has_byte: 1'b1, eos: 1'b0};
                        res.count  = 2'd2;
                    end
                end
            end
            default:
            begin
                nxt = '{mode: esd_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
            end
        endcase

        if (is_last)
        begin
            // a pending number can only exist when nothing was emitted yet
            if (nxt.mode == esd_pkg::MODE_OCT || nxt.mode == esd_pkg::MODE_HEX)
            begin
                res.first = '{data: nxt.value, has_byte: 1'b1, eos: 1'b0};
                res.count = 2'd1;
            end
            if (res.count == 2'd0)
            begin
                res.first = '{data: 8'd0, has_byte: 1'b0, eos: 1'b0};
                res.count = 2'd1;
            end
            if (res.count == 2'd2)
                res.second.eos = 1'b1;
            else
                res.first.eos = 1'b1;
            nxt = '{mode: esd_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: input stage, decode step and result queue.
//
// Usage:
//   Slave stream s_*: one escaped character per beat in s_tdata, s_tlast on the
//   final character of a string. Master stream m_*: one decoded result per beat,
//   m_tdata the byte, m_tuser set when the byte is real, m_tlast on the final
//   result of a string. A string's final beat always yields at least one result.
//   Path: an input beat is registered in the input stage, then its results are
//   written into the result queue, whose head drives m_* directly.
//   Throughput: one input beat per cycle while s_tready is high. A beat yields
//   zero, one or two results; the result queue drains one per cycle while m_tready
//   is high, so a run of two-result beats fills it and s_tready drops until it drains.
//   Input beats are registered, decoded against the escape state and pushed
//   into an eight-entry result queue; s_tready looks only at queue fill and at
//   the input stage, so it does not depend on m_tready in the same cycle.
//   When the receiver stalls, the queue fills to at most six results; s_tready drops
//   once the fill plus two for a staged beat exceeds four. Reset empties the queue and
//   the input stage and returns the decoder to plain text.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] has_byte
    output logic            m_tlast
);

    localparam int AW = esd_pkg::QUEUE_AW;

    logic                  stage_valid_reg;
    logic [7:0]            stage_byte_reg;
    logic                  stage_last_reg;
    esd_pkg::dec_state_t   state_reg;
    esd_pkg::dec_state_t   state_next;
    esd_pkg::result_pair_t res;

    esd_pkg::result_t      queue_mem [esd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]         wr_ptr_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic [AW:0]           count_reg;
    logic [AW:0]           count_next;
    logic [AW:0]           push_n;
    logic [AW:0]           reserve;
    logic                  in_beat;
    logic                  out_beat;
    esd_pkg::result_t      head;

    esd_decode u_decode (
        .cur     (state_reg),
        .in_byte (stage_byte_reg),
        .is_last (stage_last_reg),
        .nxt     (state_next),
        .res     (res)
    );

    assign reserve  = {{(AW - 1){1'b0}}, stage_valid_reg, 1'b0};
    assign s_tready = (count_reg + reserve) <= (AW + 1)'(esd_pkg::QUEUE_RESERVE);
    assign in_beat  = s_tvalid && s_tready;

    assign head     = queue_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.data;
    assign m_tuser  = head.has_byte;
    assign m_tlast  = head.eos;
    assign out_beat = m_tvalid && m_tready;

    assign push_n     = stage_valid_reg ? {{(AW - 1){1'b0}}, res.count} : '0;
    assign count_next = count_reg + push_n - {{AW{1'b0}}, out_beat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            state_reg       <= '{mode: esd_pkg::MODE_PLAIN, value: 8'd0, digits: 2'd0};
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= in_beat;
            if (stage_valid_reg)
            begin
                state_reg  <= state_next;
                wr_ptr_reg <= wr_ptr_reg + push_n[AW-1:0];
            end
            if (out_beat)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            stage_byte_reg <= s_tdata;
            stage_last_reg <= s_tlast;
        end
        if (stage_valid_reg && res.count != 2'd0)
            queue_mem[wr_ptr_reg] <= res.first;
        if (stage_valid_reg && res.count == 2'd2)
            queue_mem[wr_ptr_reg + 1'b1] <= res.second;
    end

endmodule

`default_nettype wire

// File: rtl/core/esd_checker.sv
// Port-level checks for the escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module esd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

    // a beat without a byte only marks the end of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty result beat without end mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 8'd0)
        else $error("empty result beat carries data");

    // the final character of a string always yields a result once the input stage has pushed it into the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
        else $error("no result after final input beat");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the escape sequence decoder stream block.
`timescale 1ns / 1ps

module tb_top;
    import esd_pkg::*;

    // one row of the directed sequence; typed rows carry their own results
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } char_row_t;

    localparam result_t NO_RES = '0;
    localparam int TOTAL_CHARS = 1650;
    localparam int CALM_FROM   = 1450;

    localparam char_row_t DIRECTED [28] = '{
        '{8'h41, 1'b0, 1'b1, 2'd1, '{8'h41, 1'b1, 1'b0}, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_RES},
        '{8'h01, 1'b1, 1'b1, 2'd1, '{8'h01, 1'b1, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_E, 1'b0, 1'b1, 2'd1, '{CODE_ESC, 1'b1, 1'b0}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_V, 1'b0, 1'b1, 2'd1, '{CODE_VT, 1'b1, 1'b0}, NO_RES},
        // octal 777 wraps to ff
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_SEVEN, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_SEVEN, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_SEVEN, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_RES},
        // \x with no digit gives 0, then 'G' as plain text
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_X, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h47, 1'b0, 1'b1, 2'd2, '{8'h00, 1'b1, 1'b0}, '{8'h47, 1'b1, 1'b0}},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_X, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_F, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_UPPER_F, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // pending octal flushed by the final char
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h31, 1'b1, 1'b1, 2'd1, '{8'h01, 1'b1, 1'b1}, NO_RES},
        // lone trailing backslash: empty end marker
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h71, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // number ended by a final backslash
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h32, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, '{8'h02, 1'b1, 1'b1}, NO_RES},
        '{CH_BACKSLASH, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{CH_LOWER_X, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_RES}
    };

    localparam logic [7:0] ESC_LETTERS [8] = '{
        CH_LOWER_A, CH_LOWER_B, CH_LOWER_E, CH_LOWER_F,
        CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_V
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // decoder shadow state
    mode_t      dec_mode = MODE_PLAIN;
    logic [7:0] num_value = 8'h00;
    logic [1:0] num_digits = 2'd0;

    result_t    step_results[$];
    result_t    decoded_due[$];
    result_t    oldest_due;
    logic [7:0] text[$];
    int         error_count = 0;
    int         chars_sent = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    escape_sequence_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [4:0] digit_value(input logic [7:0] ch);
        if (ch inside {[8'h30:8'h39]})
            return 5'(ch - 8'h30);
        if (ch inside {[8'h61:8'h66]})
            return 5'(ch - 8'h61 + 8'd10);
        if (ch inside {[8'h41:8'h46]})
            return 5'(ch - 8'h41 + 8'd10);
        return NO_DIGIT;
    endfunction

    task automatic emit(input logic [7:0] data, input logic has);
        step_results.insert(step_results.size(), result_t'{data, has, 1'b0});
    endtask

    task automatic clear_number();
        dec_mode   = MODE_PLAIN;
        num_value  = 8'h00;
        num_digits = 2'd0;
    endtask

    task automatic take_plain(input logic [7:0] ch);
        if (ch == CH_BACKSLASH)
            dec_mode = MODE_ESC;
        else
            emit(ch, 1'b1);
    endtask

    // advances the shadow decoder by one char, results land in step_results
    task automatic decode_char(input logic [7:0] ch, input logic last);
        int         base;
        logic [1:0] digit_limit;
        logic [4:0] dv;
        int         acc;
        step_results.delete();
        case (dec_mode)
            MODE_PLAIN:
                take_plain(ch);
            MODE_ESC:
            begin
                dec_mode = MODE_PLAIN;
                case (ch)
                    CH_LOWER_A: emit(CODE_BEL, 1'b1);
                    CH_LOWER_B: emit(CODE_BS, 1'b1);
                    CH_LOWER_E: emit(CODE_ESC, 1'b1);
                    CH_LOWER_F: emit(CODE_FF, 1'b1);
                    CH_LOWER_N: emit(CODE_LF, 1'b1);
                    CH_LOWER_R: emit(CODE_CR, 1'b1);
                    CH_LOWER_T: emit(CODE_TAB, 1'b1);
                    CH_LOWER_V: emit(CODE_VT, 1'b1);
                    CH_LOWER_X:
                    begin
                        dec_mode   = MODE_HEX;
                        num_value  = 8'h00;
                        num_digits = 2'd0;
                    end
                    default:
                    begin
                        if (ch >= CH_ZERO && ch <= CH_SEVEN)
                        begin
                            dec_mode   = MODE_OCT;
                            num_value  = ch - CH_ZERO;
                            num_digits = 2'd1;
                        end
                        else
                            emit(ch, 1'b1);
                    end
                endcase
            end
            default:
            begin
                base        = (dec_mode == MODE_OCT) ? 8 : 16;
                digit_limit = (dec_mode == MODE_OCT) ? OCT_MAX_DIGITS : HEX_MAX_DIGITS;
                dv          = digit_value(ch);
                if (int'(dv) < base && num_digits < digit_limit)
                begin
                    acc        = int'(num_value) * base + int'(dv);
                    num_value  = acc[7:0];
                    num_digits = num_digits + 2'd1;
                    if (num_digits >= digit_limit)
                    begin
                        emit(num_value, 1'b1);
                        clear_number();
                    end
                end
                else
                begin
                    emit(num_value, 1'b1);
                    clear_number();
                    take_plain(ch);
                end
            end
        endcase
        if (last)
        begin
            if (dec_mode == MODE_OCT || dec_mode == MODE_HEX)
                emit(num_value, 1'b1);
            if (step_results.size() == 0)
                emit(8'h00, 1'b0);
            step_results[step_results.size() - 1].eos = 1'b1;
            clear_number();
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                             input logic [1:0] n, input result_t r0, input result_t r1);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        decode_char(ch, last);
        if (!typed)
        begin
            foreach (step_results[i])
                decoded_due.insert(decoded_due.size(), step_results[i]);
        end
        else
        begin
            if (n > 2'd0)
                decoded_due.insert(decoded_due.size(), r0);
            if (n > 2'd1)
                decoded_due.insert(decoded_due.size(), r1);
        end
        chars_sent++;
    endtask

    // random string built from escape tokens, with some noise mixed in
    task automatic build_string();
        int         tokens;
        int         k;
        int         d;
        logic [7:0] c;
        text.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    c = 8'($urandom_range(1, 255));
                    text.insert(text.size(), c);
                end
                3, 4:
                begin
                    text.insert(text.size(), CH_BACKSLASH);
                    text.insert(text.size(), ESC_LETTERS[$urandom_range(0, 7)]);
                end
                5:
                begin
                    text.insert(text.size(), CH_BACKSLASH);
                    k = $urandom_range(1, 4);
                    repeat (k)
                    begin
                        c = CH_ZERO + 8'($urandom_range(0, 7));
                        text.insert(text.size(), c);
                    end
                end
                6:
                begin
                    text.insert(text.size(), CH_BACKSLASH);
                    text.insert(text.size(), CH_LOWER_X);
                    k = $urandom_range(0, 3);
                    repeat (k)
                    begin
                        d = $urandom_range(0, 15);
                        if (d < 10)
                            c = CH_ZERO + 8'(d);
                        else if ($urandom_range(0, 1) == 1)
                            c = CH_UPPER_A + 8'(d - 10);
                        else
                            c = CH_LOWER_A + 8'(d - 10);
                        text.insert(text.size(), c);
                    end
                end
                7:
                begin
                    text.insert(text.size(), CH_BACKSLASH);
                    c = 8'($urandom_range(1, 255));
                    text.insert(text.size(), c);
                end
                8:
                begin
                    k = $urandom_range(1, 4);
                    repeat (k)
                    begin
                        c = ($urandom_range(0, 1) == 1) ? CH_BACKSLASH
                                                        : 8'($urandom_range(1, 255));
                        text.insert(text.size(), c);
                    end
                end
                default:
                begin
                    // digit-like chars that may extend or end a number
                    c = 8'($urandom_range(8'h30, 8'h67));
                    text.insert(text.size(), c);
                end
            endcase
        end
    endtask

    // receiver backpressure
    always @(negedge clk)
    begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got data=%h has=%b eos=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                oldest_due = decoded_due.pop_front();
                if (m_tdata !== oldest_due.data || m_tuser !== oldest_due.has_byte
                    || m_tlast !== oldest_due.eos)
                begin
                    $display("%0t: mismatch, expected data=%h has=%b eos=%b, got data=%h has=%b eos=%b",
                             $time, oldest_due.data, oldest_due.has_byte, oldest_due.eos,
                             m_tdata, m_tuser, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[i])
            send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed,
                      DIRECTED[i].n, DIRECTED[i].r0, DIRECTED[i].r1);
        while (chars_sent < TOTAL_CHARS)
        begin
            quiet = (chars_sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
            build_string();
            foreach (text[i])
                send_char(text[i], i == text.size() - 1, 1'b0, 2'd0, NO_RES, NO_RES);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (decoded_due.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
